/* rtl/fvg_pkg.sv */
// types and constants shared by the fat volume geometry block
`default_nettype none

package fvg_pkg;

    typedef logic [1:0] fvg_status_t;

    localparam fvg_status_t ST_OK          = 2'd0;
    localparam fvg_status_t ST_BAD_SECTOR  = 2'd1;
    localparam fvg_status_t ST_BAD_CLUSTER = 2'd2;
    localparam fvg_status_t ST_ZERO_TOTAL  = 2'd3;

    localparam logic [15:0] SECTOR_512  = 16'd512;
    localparam logic [15:0] SECTOR_1024 = 16'd1024;
    localparam logic [15:0] SECTOR_2048 = 16'd2048;
    localparam logic [15:0] SECTOR_4096 = 16'd4096;

    // smallest sector size is 2^9 bytes
    localparam logic [3:0]  SECTOR_SHIFT_BASE = 4'd9;
    // a directory slot is 32 bytes, so the slot count shifts left by 5
    localparam int          DIR_SLOT_SHIFT    = 5;
    localparam logic [31:0] FAT12_LIMIT       = 32'd4085;

    typedef struct packed {
        logic [15:0] sector_bytes;
        logic [7:0]  cluster_sectors;
        logic [15:0] reserved_count;
        logic [7:0]  fat_copies;
        logic [15:0] root_slots;
        logic [15:0] small_total;
        logic [31:0] large_total;
        logic [15:0] fat_sectors;
    } fvg_request_t;

    typedef struct packed {
        fvg_status_t status;
        logic        is_fat16;
        logic [31:0] cluster_total;
        logic [31:0] fat_start;
        logic [31:0] root_offset;
        logic [31:0] data_offset;
    } fvg_result_t;

endpackage

`default_nettype wire

/* rtl/fat_volume_geometry.sv */
// fat volume geometry: bpb checks and layout offsets in a four stage pipeline
// done is the stage 4 valid bit; a taken request is registered through stages 1, 2, 3 and 4 before done
// throughput: one request per cycle; busy stays low as every stage moves each cycle
// sector and cluster sizes are powers of two, so all divides and scales are shifts
// the only multiplier is fat copies times fat sectors in the first stage
// reset clears the stage valid bits only; no result is pending after reset
`default_nettype none

module fat_volume_geometry
    import fvg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire fvg_request_t request,
    output logic              done,
    output fvg_result_t       result
);

    // stage 1: checks, totals, fat area product, rounded root directory bytes
    logic        v1_reg;
    fvg_status_t st1_reg, st1_next;
    logic [1:0]  bsh1_reg, bsh1_next;
    logic [2:0]  csh1_reg, csh1_next;
    logic [31:0] total1_reg, total1_next;
    logic [15:0] rsv1_reg;
    logic [23:0] fat_area1_reg, fat_area1_next;
    logic [21:0] root_sum1_reg, root_sum1_next;

    // stage 2
    logic        v2_reg;
    fvg_status_t st2_reg;
    logic [1:0]  bsh2_reg;
    logic [2:0]  csh2_reg;
    logic [12:0] root_secs2_reg, root_secs2_next;
    logic [31:0] fat_off2_reg, fat_off2_next;
    logic [31:0] fat_bytes2_reg, fat_bytes2_next;
    logic [31:0] part2_reg, part2_next;

    // stage 3
    logic        v3_reg;
    fvg_status_t st3_reg;
    logic [2:0]  csh3_reg;
    logic [31:0] data_secs3_reg, data_secs3_next;
    logic [31:0] fat_off3_reg;
    logic [31:0] root_off3_reg, root_off3_next;
    logic [31:0] root_bytes3_reg, root_bytes3_next;

    // stage 4: output register
    logic        v4_reg;
    fvg_result_t result_reg, result_next;

    logic [15:0] bps;
    logic [7:0]  spc;
    logic        bps_ok;
    logic [3:0]  shamt2;
    logic [3:0]  shamt3;
    logic [31:0] clusters;

    assign bps = request.sector_bytes;
    assign spc = request.cluster_sectors;

    always_comb
    begin
        bps_ok = (bps == SECTOR_512) || (bps == SECTOR_1024) ||
                 (bps == SECTOR_2048) || (bps == SECTOR_4096);
        total1_next = (request.small_total != 16'd0) ?
                      {16'd0, request.small_total} : request.large_total;

        if (!bps_ok)
            st1_next = ST_BAD_SECTOR;
        else if (spc == 8'd0 || (spc & (spc - 8'd1)) != 8'd0)
            st1_next = ST_BAD_CLUSTER;
        else if (total1_next == 32'd0)
            st1_next = ST_ZERO_TOTAL;
        else
            st1_next = ST_OK;

        // log2 of one-hot sizes (the sector shift counts from 2^9); meaningless when the checks fail
        bsh1_next = {bps[12] | bps[11], bps[12] | bps[10]};
        csh1_next = {|spc[7:4],
                     spc[7] | spc[6] | spc[3] | spc[2],
                     spc[7] | spc[5] | spc[3] | spc[1]};

        fat_area1_next = {16'd0, request.fat_copies} * {8'd0, request.fat_sectors};
        root_sum1_next = ({6'd0, request.root_slots} << DIR_SLOT_SHIFT)
                       + {6'd0, bps} - 22'd1;
    end

    always_comb
    begin
        shamt2          = SECTOR_SHIFT_BASE + {2'd0, bsh1_reg};
        root_secs2_next = 13'(root_sum1_reg >> shamt2);
        fat_off2_next   = {16'd0, rsv1_reg} << shamt2;
        fat_bytes2_next = {8'd0, fat_area1_reg} << shamt2;
        part2_next      = total1_reg - {16'd0, rsv1_reg} - {8'd0, fat_area1_reg};
    end

    always_comb
    begin
        shamt3           = SECTOR_SHIFT_BASE + {2'd0, bsh2_reg};
        data_secs3_next  = part2_reg - {19'd0, root_secs2_reg};
        root_off3_next   = fat_off2_reg + fat_bytes2_reg;
        root_bytes3_next = {19'd0, root_secs2_reg} << shamt3;
    end

    always_comb
    begin
        clusters    = data_secs3_reg >> csh3_reg;
        result_next = '0;
        result_next.status = st3_reg;
        if (st3_reg == ST_OK)
        begin
            result_next.is_fat16      = (clusters >= FAT12_LIMIT);
            result_next.cluster_total = clusters;
            result_next.fat_start     = fat_off3_reg;
            result_next.root_offset   = root_off3_reg;
            result_next.data_offset   = root_off3_reg + root_bytes3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_reg       <= st1_next;
        bsh1_reg      <= bsh1_next;
        csh1_reg      <= csh1_next;
        total1_reg    <= total1_next;
        rsv1_reg      <= request.reserved_count;
        fat_area1_reg <= fat_area1_next;
        root_sum1_reg <= root_sum1_next;

        st2_reg        <= st1_reg;
        bsh2_reg       <= bsh1_reg;
        csh2_reg       <= csh1_reg;
        root_secs2_reg <= root_secs2_next;
        fat_off2_reg   <= fat_off2_next;
        fat_bytes2_reg <= fat_bytes2_next;
        part2_reg      <= part2_next;

        st3_reg         <= st2_reg;
        csh3_reg        <= csh2_reg;
        data_secs3_reg  <= data_secs3_next;
        fat_off3_reg    <= fat_off2_reg;
        root_off3_reg   <= root_off3_next;
        root_bytes3_reg <= root_bytes3_next;

        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = v4_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* tb/sv/fvg_layout_checker.sv */
// layout checker for the fat volume geometry block: predicts every request and compares results
`timescale 1ns / 100ps

module fvg_layout_checker
    import fvg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         busy,
    input  wire fvg_request_t request,
    input  wire logic         done,
    input  wire fvg_result_t  result,
    output int                mismatches,
    output int                outstanding,
    output int                results_seen,
    output int                ok_volumes,
    output int                fat16_volumes
);

    fvg_result_t layouts_due[$];

    function automatic fvg_result_t layout_of(input fvg_request_t r);
        logic [31:0] bps;
        logic [31:0] spc;
        logic [31:0] total;
        logic [31:0] root_secs;
        logic [31:0] fat_area;
        logic [31:0] data_secs;
        logic [31:0] clusters;
        fvg_result_t y;
        y = '0;
        bps = {16'd0, r.sector_bytes};
        spc = {24'd0, r.cluster_sectors};
        total = (r.small_total != 16'd0) ? {16'd0, r.small_total} : r.large_total;
        if (!(bps == SECTOR_512 || bps == SECTOR_1024 || bps == SECTOR_2048
              || bps == SECTOR_4096))
            y.status = ST_BAD_SECTOR;
        else if (spc == 32'd0 || (spc & (spc - 32'd1)) != 32'd0)
            y.status = ST_BAD_CLUSTER;
        else if (total == 32'd0)
            y.status = ST_ZERO_TOTAL;
        else
        begin
            y.status = ST_OK;
            // root directory rounded up to whole sectors
            root_secs = (({16'd0, r.root_slots} << DIR_SLOT_SHIFT) + bps - 32'd1) / bps;
            fat_area = {24'd0, r.fat_copies} * {16'd0, r.fat_sectors};
            // may go below zero and wrap
            data_secs = total - {16'd0, r.reserved_count} - fat_area - root_secs;
            clusters = data_secs / spc;
            y.is_fat16 = (clusters >= FAT12_LIMIT);
            y.cluster_total = clusters;
            y.fat_start = {16'd0, r.reserved_count} * bps;
            y.root_offset = y.fat_start + fat_area * bps;
            y.data_offset = y.root_offset + root_secs * bps;
        end
        return y;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] layout mismatch: %s", $time, what);
        mismatches++;
    endtask

    initial
    begin
        mismatches = 0;
        outstanding = 0;
        results_seen = 0;
        ok_volumes = 0;
        fat16_volumes = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        fvg_result_t want;
        if (!rst_n)
        begin
            layouts_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (start && !busy)
                layouts_due.push_back(layout_of(request));
            if (done)
            begin
                results_seen++;
                if (layouts_due.size() == 0)
                    flag_mismatch("result with no request waiting");
                else
                begin
                    want = layouts_due.pop_front();
                    if (result.status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                result.status, want.status));
                    if (result.is_fat16 !== want.is_fat16)
                        flag_mismatch($sformatf("is_fat16 got %0b want %0b",
                                                result.is_fat16, want.is_fat16));
                    if (result.cluster_total !== want.cluster_total)
                        flag_mismatch($sformatf("cluster_total got %h want %h",
                                                result.cluster_total, want.cluster_total));
                    if (result.fat_start !== want.fat_start)
                        flag_mismatch($sformatf("fat_start got %h want %h",
                                                result.fat_start, want.fat_start));
                    if (result.root_offset !== want.root_offset)
                        flag_mismatch($sformatf("root_offset got %h want %h",
                                                result.root_offset, want.root_offset));
                    if (result.data_offset !== want.data_offset)
                        flag_mismatch($sformatf("data_offset got %h want %h",
                                                result.data_offset, want.data_offset));
                    if (want.status == ST_OK)
                        ok_volumes++;
                    if (want.is_fat16)
                        fat16_volumes++;
                end
            end
            outstanding <= layouts_due.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
// testbench top for the fat volume geometry block: request stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb;
    import fvg_pkg::*;

    localparam int RANDOM_REQUESTS = 1850;
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 8;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    fvg_request_t request = '0;
    logic         busy;
    logic         done;
    fvg_result_t  result;

    int mismatches;
    int outstanding;
    int results_seen;
    int ok_volumes;
    int fat16_volumes;
    int sent = 0;
    int directed_count = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fat_volume_geometry dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    fvg_layout_checker layout_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .result        (result),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .ok_volumes    (ok_volumes),
        .fat16_volumes (fat16_volumes)
    );

    // watchdog: ends the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue(input fvg_request_t r);
        int gap;
        start <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        sent++;
        // occasionally switch between back to back requests and gappy traffic
        if ($urandom_range(0, 49) == 0)
            calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            start <= 1'b0;
            request <= {$urandom, $urandom, $urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put(input logic [15:0] bps, input logic [7:0] spc, input logic [15:0] rsv,
                       input logic [7:0] nfat, input logic [15:0] rent,
                       input logic [15:0] t16, input logic [31:0] t32,
                       input logic [15:0] fsz);
        fvg_request_t r;
        r.sector_bytes = bps;
        r.cluster_sectors = spc;
        r.reserved_count = rsv;
        r.fat_copies = nfat;
        r.root_slots = rent;
        r.small_total = t16;
        r.large_total = t32;
        r.fat_sectors = fsz;
        issue(r);
    endtask

    initial
    begin
        fvg_request_t r;
        int kind;
        int k;
        int c;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests
        put(SECTOR_512, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880, 32'd0, 16'd9);
        put(SECTOR_512, 8'd4, 16'd1, 8'd2, 16'd512, 16'd0, 32'd100000, 16'd100);
        put(SECTOR_1024, 8'd2, 16'd4, 8'd2, 16'd512, 16'd40000, 32'hFFFF_FFFF, 16'd40);
        put(SECTOR_2048, 8'd16, 16'd8, 8'd1, 16'd256, 16'd0, 32'd900000, 16'd64);
        put(SECTOR_4096, 8'd64, 16'd32, 8'd2, 16'd1024, 16'd0, 32'd5000000, 16'd20);
        put(16'd0, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880, 32'd0, 16'd9);
        put(16'hFFFF, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880, 32'd0, 16'd9);
        put(16'd513, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880, 32'd0, 16'd9);
        put(16'd256, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880, 32'd0, 16'd9);
        // bad sector size wins over bad cluster size and zero total
        put(16'd0, 8'd0, 16'd0, 8'd0, 16'd0, 16'd0, 32'd0, 16'd0);
        put(SECTOR_512, 8'd0, 16'd1, 8'd2, 16'd224, 16'd2880, 32'd0, 16'd9);
        put(SECTOR_512, 8'd3, 16'd1, 8'd2, 16'd224, 16'd2880, 32'd0, 16'd9);
        put(SECTOR_512, 8'hFF, 16'd1, 8'd2, 16'd224, 16'd2880, 32'd0, 16'd9);
        // bad cluster size wins over zero total
        put(SECTOR_512, 8'd0, 16'd1, 8'd2, 16'd224, 16'd0, 32'd0, 16'd9);
        put(SECTOR_512, 8'd8, 16'd1, 8'd2, 16'd224, 16'd0, 32'd0, 16'd9);
        // either side of the fat12 limit
        put(SECTOR_512, 8'd1, 16'd0, 8'd0, 16'd0, 16'd4084, 32'd0, 16'd0);
        put(SECTOR_512, 8'd1, 16'd0, 8'd0, 16'd0, 16'd4085, 32'd0, 16'd0);
        // data sectors go negative and wrap
        put(SECTOR_512, 8'd1, 16'd100, 8'd2, 16'd512, 16'd50, 32'd0, 16'd200);
        // offsets overflow
        put(SECTOR_4096, 8'd128, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
        put(SECTOR_4096, 8'd128, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
            16'hFFFF);
        // root directory not a whole number of sectors, then a volume of one sector
        put(SECTOR_512, 8'd2, 16'd1, 8'd2, 16'd17, 16'd3000, 32'd0, 16'd3);
        put(SECTOR_512, 8'd1, 16'd0, 8'd0, 16'd0, 16'd1, 32'd0, 16'd0);
        directed_count = sent;

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            kind = $urandom_range(0, 99);
            r = {$urandom, $urandom, $urandom, $urandom};
            if (kind < 72)
            begin
                r.sector_bytes = SECTOR_512 << $urandom_range(0, 3);
                r.cluster_sectors = 8'd1 << $urandom_range(0, 7);
                if (kind < 45)
                begin
                    r.reserved_count = 16'($urandom_range(1, 32));
                    r.fat_copies = 8'($urandom_range(1, 2));
                    r.fat_sectors = 16'($urandom_range(1, 256));
                    r.root_slots = 16'($urandom_range(0, 1024));
                end
                if (kind < 22)
                begin
                    // place the cluster count near the fat12 limit
                    k = $urandom_range(0, 15);
                    c = $urandom_range(FAT12_LIMIT - 6, FAT12_LIMIT + 5);
                    r.root_slots = 16'((r.sector_bytes >> DIR_SLOT_SHIFT) * k);
                    r.small_total = '0;
                    r.large_total = r.reserved_count + r.fat_copies * r.fat_sectors + k
                                    + r.cluster_sectors * c;
                end
                else if ($urandom_range(0, 1) != 0)
                    r.small_total = '0;
                if (r.small_total == 16'd0 && r.large_total == 32'd0)
                    r.large_total = 32'd1;
            end
            else if (kind < 80)
            begin
                // legal sector size, cluster size and total left to chance
                r.sector_bytes = SECTOR_512 << $urandom_range(0, 3);
                if ($urandom_range(0, 1) != 0)
                    r.cluster_sectors = 8'd1 << $urandom_range(0, 7);
                if ($urandom_range(0, 1) != 0)
                begin
                    r.small_total = '0;
                    r.large_total = '0;
                end
            end
            else if (kind < 90)
            begin
                // one bit away from a legal sector size
                r.sector_bytes = (SECTOR_512 << $urandom_range(0, 3))
                                 ^ (16'd1 << $urandom_range(0, 15));
                if ($urandom_range(0, 1) != 0)
                    r.cluster_sectors = 8'd1 << $urandom_range(0, 7);
            end
            issue(r);
        end

        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests sent (%0d directed), %0d results compared",
                 sent, directed_count, results_seen);
        $display("%0d volumes passed the checks (%0d fat16), %0d rejected",
                 ok_volumes, fat16_volumes, results_seen - ok_volumes);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
